// ===== rtl/cumt_pkg.sv =====
// shared types and constants for the card to owner match table
package cumt_pkg;

    localparam logic [7:0] EMPTY_OWNER = 8'hFF;
    localparam int RESULT_CAP = 32;
    localparam int CNT_W = 6;

    typedef enum logic [2:0] {
        FN_LOOKUP = 3'd0,
        FN_INSERT = 3'd1,
        FN_DELETE = 3'd2,
        FN_ALLOC  = 3'd3,
        FN_LIST   = 3'd4
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_BMAP = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic bmap;
        logic fin;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic bmap_done;
        logic need_bmap;
        logic out_free;
    } sts_t;

    typedef struct packed {
        logic [63:0] nonce_low;
        logic [63:0] nonce_high;
        logic [63:0] code;
    } entry_t;

endpackage

// ===== rtl/card_user_match_table.sv =====
// card to owner match table, top level
// timing: the scan reads one table entry per cycle unless a list result waits on the output,
// and allocate adds a scan of the id bitmap after it; the block takes no new operation
// until the result of the last one has been loaded into the output register,
// and list results leave at up to one beat per cycle while the scan runs and m_tready is high
// reset: synchronous active-low aresetn empties every entry at once through per-entry
// written bits; the table holds no other reset state
module card_user_match_table #(
    parameter int TABLE_ENTRIES = 32,
    parameter int MAX_USERS     = 16,
    parameter int CODE_BYTES    = 8,
    parameter int NONCE_BYTES   = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [199:0] s_tdata,   // card_code, nonce_high, nonce_low, owner_id
    input  logic [2:0]   s_tuser,   // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [207:0] m_tdata,   // owner_out, code_out, nonce_high_out, nonce_low_out, free_ids
    output logic [0:0]   m_tuser,   // status
    output logic         m_tlast
);

    cumt_pkg::cmd_t cmd;
    cumt_pkg::sts_t sts;

    logic        out_status;
    logic [7:0]  out_owner;
    logic [63:0] out_code;
    logic [63:0] out_nonce_high;
    logic [63:0] out_nonce_low;
    logic [7:0]  out_free_ids;

    cumt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cumt_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_USERS     (MAX_USERS),
        .CODE_BYTES    (CODE_BYTES),
        .NONCE_BYTES   (NONCE_BYTES)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .in_func        (s_tuser),
        .in_code        (s_tdata[63:0]),
        .in_nonce_high  (s_tdata[127:64]),
        .in_nonce_low   (s_tdata[191:128]),
        .in_owner       (s_tdata[199:192]),
        .m_tready       (m_tready),
        .out_valid      (m_tvalid),
        .out_status     (out_status),
        .out_owner      (out_owner),
        .out_code       (out_code),
        .out_nonce_high (out_nonce_high),
        .out_nonce_low  (out_nonce_low),
        .out_free_ids   (out_free_ids),
        .out_last       (m_tlast)
    );

    assign m_tdata = {out_free_ids, out_nonce_low, out_nonce_high, out_code, out_owner};
    assign m_tuser = out_status;

endmodule

// ===== rtl/cumt_ctrl.sv =====
// operation sequencer: idle, table scan, id bitmap scan, final result
module cumt_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  cumt_pkg::sts_t sts,
    output cumt_pkg::cmd_t cmd
);

    cumt_pkg::state_t state_reg;
    cumt_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cumt_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cumt_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = cumt_pkg::ST_SCAN;
            end
            cumt_pkg::ST_SCAN: begin
                if (sts.scan_done) begin
                    state_next = sts.need_bmap ? cumt_pkg::ST_BMAP : cumt_pkg::ST_FIN;
                end
            end
            cumt_pkg::ST_BMAP: begin
                if (sts.bmap_done) state_next = cumt_pkg::ST_FIN;
            end
            cumt_pkg::ST_FIN: begin
                if (sts.out_free) state_next = cumt_pkg::ST_IDLE;
            end
            default: state_next = cumt_pkg::ST_IDLE;
        endcase
    end

    assign s_tready = (state_reg == cumt_pkg::ST_IDLE);

    always_comb begin
        cmd.load = (state_reg == cumt_pkg::ST_IDLE) && s_tvalid;
        cmd.scan = (state_reg == cumt_pkg::ST_SCAN);
        cmd.bmap = (state_reg == cumt_pkg::ST_BMAP);
        cmd.fin  = (state_reg == cumt_pkg::ST_FIN) && sts.out_free;
    end

endmodule

// ===== rtl/cumt_dp.sv =====
// table memories, scan pipeline, id bitmap and result register
module cumt_dp #(
    parameter int TABLE_ENTRIES = 32,
    parameter int MAX_USERS     = 16,
    parameter int CODE_BYTES    = 8,
    parameter int NONCE_BYTES   = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  cumt_pkg::cmd_t cmd,
    output cumt_pkg::sts_t sts,
    input  logic [2:0]     in_func,
    input  logic [63:0]    in_code,
    input  logic [63:0]    in_nonce_high,
    input  logic [63:0]    in_nonce_low,
    input  logic [7:0]     in_owner,
    input  logic           m_tready,
    output logic           out_valid,
    output logic           out_status,
    output logic [7:0]     out_owner,
    output logic [63:0]    out_code,
    output logic [63:0]    out_nonce_high,
    output logic [63:0]    out_nonce_low,
    output logic [7:0]     out_free_ids,
    output logic           out_last
);

    localparam int AW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW   = $clog2(TABLE_ENTRIES + 1);
    localparam int UIDW = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
    localparam int UCW  = $clog2(MAX_USERS + 1);
    localparam logic [63:0] CODE_MASK = (CODE_BYTES >= 8) ? {64{1'b1}} :
        ((64'd1 << (8 * CODE_BYTES)) - 64'd1);
    localparam logic [63:0] NL_MASK = (NONCE_BYTES >= 8) ? {64{1'b1}} :
        ((64'd1 << (8 * NONCE_BYTES)) - 64'd1);
    localparam logic [63:0] NH_MASK = (NONCE_BYTES >= 16) ? {64{1'b1}} :
        (NONCE_BYTES <= 8) ? 64'd0 : ((64'd1 << (8 * (NONCE_BYTES - 8))) - 64'd1);

    // storage
    logic [7:0]              owner_mem [TABLE_ENTRIES];
    cumt_pkg::entry_t        data_mem  [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] written_reg;
    logic [7:0]              owner_rd_reg;
    cumt_pkg::entry_t        data_rd_reg;
    logic                    written_rd_reg;

    // operation
    cumt_pkg::func_t func_reg;
    logic [63:0]     code_reg;
    logic [63:0]     nh_reg;
    logic [63:0]     nl_reg;
    logic [7:0]      own_reg;

    // scan
    logic [CW-1:0] idx_reg;
    logic          rd_vld_reg;
    logic [AW-1:0] rd_idx_reg;

    logic          hold_vld_reg;
    logic [7:0]    hold_own_reg;
    logic [63:0]   hold_code_reg;
    logic [63:0]   hold_nh_reg;
    logic [63:0]   hold_nl_reg;
    logic          empty_vld_reg;
    logic [AW-1:0] empty_slot_reg;
    logic [cumt_pkg::CNT_W-1:0] cnt_reg;

    // id bitmap
    logic [MAX_USERS-1:0] used_reg;
    logic [UCW-1:0]       uid_reg;
    logic [7:0]           free_reg;
    logic                 first_vld_reg;
    logic [7:0]           first_reg;

    // result register
    logic        out_vld_reg;
    logic        out_status_reg;
    logic [7:0]  out_owner_reg;
    logic [63:0] out_code_reg;
    logic [63:0] out_nh_reg;
    logic [63:0] out_nl_reg;
    logic [7:0]  out_free_reg;
    logic        out_last_reg;

    logic        status_next;
    logic [7:0]  owner_next;
    logic [63:0] code_next;
    logic [63:0] nh_next;
    logic [63:0] nl_next;
    logic [7:0]  free_next;
    logic        last_next;

    logic       out_free;
    logic       issue;
    logic [7:0] owner_q;
    logic       ent_valid;
    logic       code_hit;
    logic       list_hit;
    logic       stall;
    logic       advance;
    logic       proc;
    logic       push;
    logic       bstep;
    logic       ins_ok;
    logic       out_load;

    assign out_free  = !out_vld_reg || m_tready;
    assign issue     = (idx_reg < CW'(TABLE_ENTRIES));
    // an entry never written reads as empty
    assign owner_q   = written_rd_reg ? owner_rd_reg : cumt_pkg::EMPTY_OWNER;
    assign ent_valid = (owner_q < 8'(MAX_USERS));
    assign code_hit  = ent_valid && (((data_rd_reg.code ^ code_reg) & CODE_MASK) == 64'd0);
    assign list_hit  = rd_vld_reg && (func_reg == cumt_pkg::FN_LIST)
                    && (own_reg < 8'(MAX_USERS)) && (owner_q == own_reg)
                    && (cnt_reg < cumt_pkg::CNT_W'(cumt_pkg::RESULT_CAP));
    // a held list entry goes out when the next one shows up
    assign stall     = list_hit && hold_vld_reg && !out_free;
    assign advance   = cmd.scan && !stall;
    assign proc      = advance && rd_vld_reg;
    assign push      = proc && list_hit && hold_vld_reg;
    assign bstep     = cmd.bmap && (uid_reg != UCW'(MAX_USERS));
    assign ins_ok    = empty_vld_reg && !hold_vld_reg;
    assign out_load  = cmd.fin || push;

    always_comb begin
        sts.scan_done = !issue && !rd_vld_reg;
        sts.bmap_done = (uid_reg == UCW'(MAX_USERS));
        sts.need_bmap = (func_reg == cumt_pkg::FN_ALLOC);
        sts.out_free  = out_free;
    end

    // memories
    always_ff @(posedge aclk) begin
        if (cmd.fin && (func_reg == cumt_pkg::FN_INSERT) && ins_ok) begin
            owner_mem[empty_slot_reg] <= own_reg;
            data_mem[empty_slot_reg]  <= '{nonce_low:  nl_reg & NL_MASK,
                                           nonce_high: nh_reg & NH_MASK,
                                           code:       code_reg & CODE_MASK};
        end
        if (advance && issue) begin
            owner_rd_reg <= owner_mem[idx_reg[AW-1:0]];
            data_rd_reg  <= data_mem[idx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
        end else begin
            if (proc && (func_reg == cumt_pkg::FN_DELETE) && (owner_q == own_reg)) begin
                written_reg[rd_idx_reg] <= 1'b0;
            end
            if (cmd.fin && (func_reg == cumt_pkg::FN_INSERT) && ins_ok) begin
                written_reg[empty_slot_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && issue) begin
            written_rd_reg <= written_reg[idx_reg[AW-1:0]];
        end
    end

    // operation capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= cumt_pkg::func_t'(in_func);
            code_reg <= in_code;
            nh_reg   <= in_nonce_high;
            nl_reg   <= in_nonce_low;
            own_reg  <= in_owner;
        end
    end

    // scan and bitmap control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            hold_vld_reg  <= 1'b0;
            empty_vld_reg <= 1'b0;
            cnt_reg       <= '0;
            used_reg      <= '0;
            uid_reg       <= '0;
            free_reg      <= '0;
            first_vld_reg <= 1'b0;
        end else if (cmd.load) begin
            idx_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            hold_vld_reg  <= 1'b0;
            empty_vld_reg <= 1'b0;
            cnt_reg       <= '0;
            used_reg      <= '0;
            uid_reg       <= '0;
            free_reg      <= '0;
            first_vld_reg <= 1'b0;
        end else begin
            if (advance) begin
                rd_vld_reg <= issue;
                if (issue) begin
                    rd_idx_reg <= idx_reg[AW-1:0];
                    idx_reg    <= idx_reg + CW'(1);
                end
            end
            if (proc) begin
                priority case (1'b1)
                    (func_reg == cumt_pkg::FN_LOOKUP) || (func_reg == cumt_pkg::FN_INSERT): begin
                        if (code_hit && !hold_vld_reg) begin
                            hold_vld_reg  <= 1'b1;
                            hold_own_reg  <= owner_q;
                            hold_nh_reg   <= data_rd_reg.nonce_high;
                            hold_nl_reg   <= data_rd_reg.nonce_low;
                        end
                        if (!ent_valid && !empty_vld_reg) begin
                            empty_vld_reg  <= 1'b1;
                            empty_slot_reg <= rd_idx_reg;
                        end
                    end
                    (func_reg == cumt_pkg::FN_LIST): begin
                        if (list_hit) begin
                            hold_vld_reg  <= 1'b1;
                            hold_code_reg <= data_rd_reg.code;
                            hold_nh_reg   <= data_rd_reg.nonce_high;
                            hold_nl_reg   <= data_rd_reg.nonce_low;
                            cnt_reg       <= cnt_reg + cumt_pkg::CNT_W'(1);
                        end
                    end
                    (func_reg == cumt_pkg::FN_ALLOC): begin
                        if (ent_valid) used_reg[owner_q[UIDW-1:0]] <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            if (bstep) begin
                uid_reg <= uid_reg + UCW'(1);
                if (!used_reg[uid_reg[UIDW-1:0]]) begin
                    free_reg <= free_reg + 8'd1;
                    if (!first_vld_reg) begin
                        first_vld_reg <= 1'b1;
                        first_reg     <= 8'(uid_reg);
                    end
                end
            end
        end
    end

    // result selection
    always_comb begin
        status_next = 1'b1;
        owner_next  = 8'd0;
        code_next   = 64'd0;
        nh_next     = 64'd0;
        nl_next     = 64'd0;
        free_next   = 8'd0;
        last_next   = 1'b1;
        if (cmd.fin) begin
            unique case (func_reg)
                cumt_pkg::FN_LOOKUP: begin
                    if (hold_vld_reg) begin
                        status_next = 1'b0;
                        owner_next  = hold_own_reg;
                        nh_next     = hold_nh_reg;
                        nl_next     = hold_nl_reg;
                    end
                end
                cumt_pkg::FN_INSERT: status_next = !ins_ok;
                cumt_pkg::FN_DELETE: status_next = 1'b0;
                cumt_pkg::FN_ALLOC: begin
                    if (first_vld_reg) begin
                        status_next = 1'b0;
                        owner_next  = first_reg;
                        free_next   = free_reg;
                    end
                end
                cumt_pkg::FN_LIST: begin
                    if (hold_vld_reg) begin
                        status_next = 1'b0;
                        code_next   = hold_code_reg;
                        nh_next     = hold_nh_reg;
                        nl_next     = hold_nl_reg;
                    end
                end
                default: status_next = 1'b1;
            endcase
        end else begin
            // earlier list entry, more follow
            status_next = 1'b0;
            code_next   = hold_code_reg;
            nh_next     = hold_nh_reg;
            nl_next     = hold_nl_reg;
            last_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_load) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_status_reg <= status_next;
            out_owner_reg  <= owner_next;
            out_code_reg   <= code_next;
            out_nh_reg     <= nh_next;
            out_nl_reg     <= nl_next;
            out_free_reg   <= free_next;
            out_last_reg   <= last_next;
        end
    end

    assign out_valid      = out_vld_reg;
    assign out_status     = out_status_reg;
    assign out_owner      = out_owner_reg;
    assign out_code       = out_code_reg;
    assign out_nonce_high = out_nh_reg;
    assign out_nonce_low  = out_nl_reg;
    assign out_free_ids   = out_free_reg;
    assign out_last       = out_last_reg;

endmodule

// ===== sim/match_table_checker.sv =====
// scoreboard for the card to owner match table: predicts result beats and compares them
module match_table_checker
    import cumt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 32,
    parameter int MAX_USERS     = 16,
    parameter int CODE_BYTES    = 8,
    parameter int NONCE_BYTES   = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [199:0] s_tdata,   // card_code, nonce_high, nonce_low, owner_id
    input  logic [2:0]   s_tuser,   // func
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [207:0] m_tdata,   // owner_out, code_out, nonce_high_out, nonce_low_out, free_ids
    input  logic [0:0]   m_tuser,   // status
    input  logic         m_tlast,
    output int           mismatch_count,
    output int           beats_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        status;
        logic [7:0]  owner;
        logic [63:0] code;
        logic [63:0] nonce_high;
        logic [63:0] nonce_low;
        logic [7:0]  free_ids;
        logic        last;
    } table_beat_t;

    logic [7:0]  slot_owner      [TABLE_ENTRIES];
    logic [63:0] slot_code       [TABLE_ENTRIES];
    logic [63:0] slot_nonce_high [TABLE_ENTRIES];
    logic [63:0] slot_nonce_low  [TABLE_ENTRIES];

    table_beat_t expected_beats [$];
    table_beat_t seen_beat;
    table_beat_t oldest_beat;
    int          fail_total = 0;

    assign seen_beat = {m_tuser[0], m_tdata[7:0], m_tdata[71:8], m_tdata[135:72],
                        m_tdata[199:136], m_tdata[207:200], m_tlast};

    function automatic logic [63:0] byte_span(int bytes);
        if (bytes <= 0)
            return '0;
        if (bytes >= 8)
            return '1;
        return (64'd1 << (8 * bytes)) - 64'd1;
    endfunction

    function automatic logic slot_live(int i);
        return slot_owner[i] < MAX_USERS;
    endfunction

    function automatic int find_card(logic [63:0] code);
        logic [63:0] m;
        m = byte_span(CODE_BYTES);
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (slot_live(i) && (slot_code[i] & m) == (code & m))
                return i;
        return -1;
    endfunction

    function automatic void push_beat(logic status, logic [7:0] owner, logic [63:0] code,
                                      logic [63:0] nh, logic [63:0] nl, logic [7:0] free_ids,
                                      logic last);
        expected_beats.push_back({status, owner, code, nh, nl, free_ids, last});
    endfunction

    // not found, full, duplicate, none free or unknown func
    function automatic void push_refusal();
        push_beat(1'b1, '0, '0, '0, '0, '0, 1'b1);
    endfunction

    function automatic void predict_op(logic [2:0] fn, logic [63:0] code, logic [63:0] nh,
                                       logic [63:0] nl, logic [7:0] owner);
        int           hit;
        int           slot;
        int           match_cnt;
        int           k;
        int           first_free;
        int           free_cnt;
        logic [255:0] taken;
        case (fn)
            FN_LOOKUP: begin
                hit = find_card(code);
                if (hit < 0)
                    push_refusal();
                else
                    push_beat(1'b0, slot_owner[hit], '0, slot_nonce_high[hit],
                              slot_nonce_low[hit], '0, 1'b1);
            end
            FN_INSERT: begin
                slot = -1;
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (slot < 0 && !slot_live(i))
                        slot = i;
                if (slot < 0 || find_card(code) >= 0) begin
                    push_refusal();
                end else begin
                    // an out-of-range owner is stored as given and the slot stays empty
                    slot_owner[slot]      = owner;
                    slot_code[slot]       = code & byte_span(CODE_BYTES);
                    slot_nonce_low[slot]  = nl & byte_span(NONCE_BYTES);
                    slot_nonce_high[slot] = nh & byte_span(NONCE_BYTES - 8);
                    push_beat(1'b0, '0, '0, '0, '0, '0, 1'b1);
                end
            end
            FN_DELETE: begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (slot_owner[i] == owner)
                        slot_owner[i] = EMPTY_OWNER;
                push_beat(1'b0, '0, '0, '0, '0, '0, 1'b1);
            end
            FN_ALLOC: begin
                taken = '0;
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (slot_live(i))
                        taken[slot_owner[i]] = 1'b1;
                first_free = -1;
                free_cnt   = 0;
                for (int i = 0; i < MAX_USERS && i < 256; i++)
                    if (!taken[i]) begin
                        free_cnt++;
                        if (first_free < 0)
                            first_free = i;
                    end
                if (first_free < 0)
                    push_refusal();
                else
                    push_beat(1'b0, 8'(first_free), '0, '0, '0, 8'(free_cnt), 1'b1);
            end
            FN_LIST: begin
                match_cnt = 0;
                if (owner < MAX_USERS)
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                        if (slot_owner[i] == owner)
                            match_cnt++;
                if (match_cnt > RESULT_CAP)
                    match_cnt = RESULT_CAP;
                if (match_cnt == 0) begin
                    push_refusal();
                end else begin
                    k = 0;
                    for (int i = 0; i < TABLE_ENTRIES && k < match_cnt; i++)
                        if (slot_owner[i] == owner) begin
                            push_beat(1'b0, '0, slot_code[i], slot_nonce_high[i],
                                      slot_nonce_low[i], '0, k == match_cnt - 1);
                            k++;
                        end
                end
            end
            default: push_refusal();
        endcase
    endfunction

    function automatic string show_beat(table_beat_t b);
        return $sformatf("st=%0b own=%0h code=%h nh=%h nl=%h free=%0d last=%0b",
                         b.status, b.owner, b.code, b.nonce_high, b.nonce_low,
                         b.free_ids, b.last);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                slot_owner[i]      = EMPTY_OWNER;
                slot_code[i]       = '0;
                slot_nonce_high[i] = '0;
                slot_nonce_low[i]  = '0;
            end
            expected_beats.delete();
        end else begin
            // input side first: its results cannot leave on the same edge
            if (s_tvalid && s_tready)
                predict_op(s_tuser, s_tdata[63:0], s_tdata[127:64], s_tdata[191:128],
                           s_tdata[199:192]);
            if (m_tvalid && m_tready) begin
                if (expected_beats.size() == 0) begin
                    if (fail_total < 10)
                        $display("%0t: result beat with nothing expected: %s",
                                 $realtime, show_beat(seen_beat));
                    fail_total++;
                end else begin
                    oldest_beat = expected_beats.pop_front();
                    if (seen_beat !== oldest_beat) begin
                        if (fail_total < 10) begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  expected %s", show_beat(oldest_beat));
                            $display("  actual   %s", show_beat(seen_beat));
                        end
                        fail_total++;
                    end
                end
            end
        end
        mismatch_count <= fail_total;
        beats_pending  <= expected_beats.size();
    end

endmodule

// ===== sim/card_user_match_table_tb.sv =====
// testbench top for the card to owner match table: stimulus, timeout and verdict
module card_user_match_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cumt_pkg::*;

    localparam int TABLE_ENTRIES = 32;
    localparam int MAX_USERS     = 16;
    localparam int CODE_BYTES    = 8;
    localparam int NONCE_BYTES   = 16;
    localparam int RANDOM_ITEMS  = 245;
    localparam int POOL_SIZE     = 24;
    localparam int DRAIN_CYCLES  = TABLE_ENTRIES + MAX_USERS + 8;
    localparam int CYCLE_LIMIT   = 1_000_000;

    // func codes the block does not implement
    localparam logic [2:0] FN_RSVD_LO  = 3'd5;
    localparam logic [2:0] FN_RSVD_MID = 3'd6;
    localparam logic [2:0] FN_RSVD_HI  = 3'd7;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [199:0] s_tdata  = '0;   // card_code, nonce_high, nonce_low, owner_id
    logic [2:0]   s_tuser  = '0;   // func
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [207:0] m_tdata;         // owner_out, code_out, nonce_high_out, nonce_low_out, free_ids
    logic [0:0]   m_tuser;         // status
    logic         m_tlast;

    int          mismatch_count;
    int          beats_pending;
    int          cycle_count = 0;
    int          sent_count  = 0;
    bit          tx_quiet    = 1'b0;
    bit          rx_quiet    = 1'b0;
    int          rx_hold     = 0;
    int          rx_gap;
    logic [63:0] code_pool [POOL_SIZE];

    card_user_match_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .MAX_USERS    (MAX_USERS),
        .CODE_BYTES   (CODE_BYTES),
        .NONCE_BYTES  (NONCE_BYTES)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    match_table_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .MAX_USERS    (MAX_USERS),
        .CODE_BYTES   (CODE_BYTES),
        .NONCE_BYTES  (NONCE_BYTES)
    ) checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .mismatch_count(mismatch_count),
        .beats_pending (beats_pending)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // mostly short gaps, a few long ones, none at all while quiet
    function automatic int idle_gap(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 20);
    endfunction

    // result side back-pressure
    always @(posedge aclk) begin
        if (rx_hold != 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= (rx_hold == 1);
        end else begin
            if ($urandom_range(0, 63) == 0)
                rx_quiet <= !rx_quiet;
            rx_gap = idle_gap(rx_quiet);
            rx_hold  <= rx_gap;
            m_tready <= (rx_gap == 0);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // half the codes repeat from a small pool so lookups hit and inserts collide
    function automatic logic [63:0] pick_code();
        if ($urandom_range(0, 1) == 0)
            return code_pool[$urandom_range(0, POOL_SIZE - 1)];
        return rand64();
    endfunction

    function automatic logic [7:0] pick_owner();
        if ($urandom_range(0, 99) < 85)
            return 8'($urandom_range(0, MAX_USERS - 1));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_op(logic [2:0] fn, logic [63:0] code, logic [63:0] nh,
                           logic [63:0] nl, logic [7:0] owner);
        int gap;
        if ($urandom_range(0, 39) == 0)
            tx_quiet = !tx_quiet;
        gap = idle_gap(tx_quiet);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {owner, nl, nh, code};
        @(negedge aclk);
        while (!s_tready)
            @(negedge aclk);
        @(posedge aclk);
        sent_count++;
    endtask

    task automatic random_op();
        int         r;
        logic [2:0] fn;
        r = $urandom_range(0, 99);
        if (r < 35)
            fn = FN_INSERT;
        else if (r < 57)
            fn = FN_LOOKUP;
        else if (r < 72)
            fn = FN_LIST;
        else if (r < 80)
            fn = FN_DELETE;
        else if (r < 90)
            fn = FN_ALLOC;
        else if (r < 95)
            fn = 3'($urandom_range(FN_RSVD_LO, FN_RSVD_HI));
        else
            fn = 3'($urandom_range(0, 7));
        send_op(fn, pick_code(), rand64(), rand64(), pick_owner());
    endtask

    task automatic clear_owners();
        for (int o = 0; o < MAX_USERS; o++)
            send_op(FN_DELETE, rand64(), rand64(), rand64(), 8'(o));
    endtask

    // whole table to one owner, so its list hits the result cap and the next insert fails
    task automatic fill_one_owner();
        logic [7:0]  who;
        logic [63:0] kept;
        who = 8'($urandom_range(0, MAX_USERS - 1));
        clear_owners();
        for (int n = 0; n < TABLE_ENTRIES; n++) begin
            kept = rand64();
            send_op(FN_INSERT, kept, rand64(), rand64(), who);
        end
        send_op(FN_LIST, rand64(), rand64(), rand64(), who);
        send_op(FN_INSERT, rand64(), rand64(), rand64(), pick_owner());
        send_op(FN_LOOKUP, kept, rand64(), rand64(), pick_owner());
        send_op(FN_ALLOC, rand64(), rand64(), rand64(), pick_owner());
    endtask

    // every owner id in use, then one freed again
    task automatic use_all_owners();
        for (int o = 0; o < MAX_USERS; o++)
            send_op(FN_DELETE, rand64(), rand64(), rand64(), 8'(o));
        for (int o = 0; o < MAX_USERS; o++)
            send_op(FN_INSERT, rand64(), rand64(), rand64(), 8'(o));
        send_op(FN_ALLOC, rand64(), rand64(), rand64(), pick_owner());
        send_op(FN_DELETE, rand64(), rand64(), rand64(), 8'(pick_owner() % MAX_USERS));
        send_op(FN_ALLOC, rand64(), rand64(), rand64(), pick_owner());
    endtask

    initial begin
        int base;
        int fill_at;
        int owners_at;
        bit filled;
        bit owners_done;

        for (int k = 0; k < POOL_SIZE; k++)
            code_pool[k] = rand64();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty table, extremes, duplicates, out-of-range owners, unused funcs
        send_op(FN_LOOKUP, '0, rand64(), rand64(), 8'(rand64()));
        send_op(FN_LIST, rand64(), rand64(), rand64(), 8'd0);
        send_op(FN_ALLOC, rand64(), rand64(), rand64(), 8'(rand64()));
        send_op(FN_INSERT, '1, '1, '1, 8'(MAX_USERS - 1));
        send_op(FN_INSERT, '0, '0, '0, 8'd0);
        send_op(FN_INSERT, '1, rand64(), rand64(), 8'd3);
        send_op(FN_LOOKUP, '1, rand64(), rand64(), 8'(rand64()));
        send_op(FN_LOOKUP, '0, rand64(), rand64(), 8'(rand64()));
        send_op(FN_INSERT, 64'hA5A5_A5A5_A5A5_A5A5, rand64(), rand64(), 8'(MAX_USERS));
        send_op(FN_LOOKUP, 64'hA5A5_A5A5_A5A5_A5A5, rand64(), rand64(), 8'(rand64()));
        send_op(FN_INSERT, 64'h5A5A_5A5A_5A5A_5A5A, rand64(), rand64(), EMPTY_OWNER);
        send_op(FN_LIST, rand64(), rand64(), rand64(), EMPTY_OWNER);
        send_op(FN_LIST, rand64(), rand64(), rand64(), 8'(MAX_USERS));
        send_op(FN_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                64'hAAAA_AAAA_AAAA_AAAA, 8'd0);
        send_op(FN_LIST, rand64(), rand64(), rand64(), 8'd0);
        send_op(FN_ALLOC, rand64(), rand64(), rand64(), 8'(rand64()));
        send_op(FN_DELETE, rand64(), rand64(), rand64(), 8'd0);
        send_op(FN_LOOKUP, '0, rand64(), rand64(), 8'(rand64()));
        send_op(FN_LIST, rand64(), rand64(), rand64(), 8'd0);
        send_op(FN_DELETE, rand64(), rand64(), rand64(), 8'd7);
        send_op(FN_RSVD_LO, rand64(), rand64(), rand64(), 8'(rand64()));
        send_op(FN_RSVD_MID, rand64(), rand64(), rand64(), 8'(rand64()));
        send_op(FN_RSVD_HI, rand64(), rand64(), rand64(), 8'(rand64()));
        send_op(FN_LIST, rand64(), rand64(), rand64(), 8'(MAX_USERS - 1));
        send_op(FN_ALLOC, rand64(), rand64(), rand64(), 8'(rand64()));

        base        = sent_count;
        fill_at     = $urandom_range(20, 150);
        owners_at   = $urandom_range(60, 200);
        filled      = 1'b0;
        owners_done = 1'b0;
        while (sent_count - base < RANDOM_ITEMS) begin
            if (!filled && sent_count - base >= fill_at) begin
                fill_one_owner();
                filled = 1'b1;
            end else if (!owners_done && sent_count - base >= owners_at) begin
                use_all_owners();
                owners_done = 1'b1;
            end else begin
                random_op();
            end
        end
        s_tvalid <= 1'b0;

        do
            @(negedge aclk);
        while (beats_pending != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (mismatch_count == 0 && beats_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/cumt_pkg.sv
rtl/cumt_ctrl.sv
rtl/cumt_dp.sv
rtl/card_user_match_table.sv
sim/match_table_checker.sv
sim/card_user_match_table_tb.sv
